// ===== src/i2cm_pkg.sv =====
// Shared types and codes for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the action field
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_START_A   = 4'd1;
    localparam logic [3:0] ST_START_B   = 4'd2;
    localparam logic [3:0] ST_STOP_A    = 4'd3;
    localparam logic [3:0] ST_STOP_B    = 4'd4;
    localparam logic [3:0] ST_STOP_C    = 4'd5;
    localparam logic [3:0] ST_WR_LOW    = 4'd6;
    localparam logic [3:0] ST_WR_HIGH   = 4'd7;
    localparam logic [3:0] ST_WACK_LOW  = 4'd8;
    localparam logic [3:0] ST_WACK_HIGH = 4'd9;
    localparam logic [3:0] ST_RD_LOW    = 4'd10;
    localparam logic [3:0] ST_RD_HIGH   = 4'd11;
    localparam logic [3:0] ST_RACK_LOW  = 4'd12;
    localparam logic [3:0] ST_RACK_HIGH = 4'd13;

    // Bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Half period after reset
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

    // One command or tick item
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_data;
        logic       nack_level;
        logic       sda_in;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_byte;
        logic       rejected;
    } res_t;

endpackage

`default_nettype wire

// ===== src/i2cm_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one command or tick item.
`default_nettype none

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] write_data;
    logic       nack_level;
    logic       sda_in;

    modport source (output valid, output action, output write_data, output nack_level,
                    output sda_in, input ready);
    modport sink (input valid, input action, input write_data, input nack_level,
                  input sda_in, output ready);
endinterface

`default_nettype wire

// ===== src/i2cm_res_if.sv =====
// Result channel: valid/ready handshake carrying line levels and status.
`default_nettype none

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, output scl_level, output sda_level, output sda_drive,
                    output busy_res, output done_res, output ack_ok, output read_byte,
                    output rejected, input ready);
    modport sink (input valid, input scl_level, input sda_level, input sda_drive,
                  input busy_res, input done_res, input ack_ok, input read_byte,
                  input rejected, output ready);
endinterface

`default_nettype wire

// ===== src/i2cm_seq.sv =====
// Bus sequencer: state registers and the combinational update for one item.
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire cmd_t        item,
    input  wire logic [15:0] half_period,
    output res_t             res_next
);

    logic [3:0]  state_reg, state_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        ack_held_reg, ack_held_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;

    logic        busy;
    logic        done;
    logic        rejected;
    logic [15:0] hp;
    logic [15:0] delay_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_wr;
    logic [7:0]  shift_rd;

    assign busy      = (state_reg != ST_IDLE);
    assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
    assign delay_inc = delay_reg + 16'd1;
    assign bit_inc   = bit_cnt_reg + 4'd1;
    assign shift_wr  = {shift_reg[6:0], 1'b0};
    assign shift_rd  = {shift_reg[6:0], item.sda_in};

    // Next state for the item in hand
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        ack_flag_next  = ack_flag_reg;
        ack_held_next  = ack_held_reg;
        last_read_next = last_read_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drive_next     = drive_reg;
        done           = 1'b0;
        rejected       = 1'b0;

        unique case (item.action) inside
            ACT_TICK:
            begin
                if (busy)
                begin
                    delay_next = delay_inc;
                    if (delay_inc >= hp)
                    begin
                        delay_next = 16'd0;
                        // Phase end
                        unique case (state_reg)
                            ST_START_A:
                            begin
                                sda_next   = 1'b0;
                                drive_next = 1'b1;
                                state_next = ST_START_B;
                            end
                            ST_START_B:
                            begin
                                scl_next   = 1'b0;
                                state_next = ST_IDLE;
                                done       = 1'b1;
                            end
                            ST_STOP_A:
                            begin
                                scl_next   = 1'b1;
                                state_next = ST_STOP_B;
                            end
                            ST_STOP_B:
                            begin
                                sda_next   = 1'b1;
                                drive_next = 1'b1;
                                state_next = ST_STOP_C;
                            end
                            ST_STOP_C:
                            begin
                                state_next = ST_IDLE;
                                done       = 1'b1;
                            end
                            ST_WR_LOW:
                            begin
                                scl_next   = 1'b1;
                                state_next = ST_WR_HIGH;
                            end
                            ST_WR_HIGH:
                            begin
                                scl_next     = 1'b0;
                                bit_cnt_next = bit_inc;
                                shift_next   = shift_wr;
                                if (bit_inc < BITS_PER_BYTE)
                                begin
                                    sda_next   = shift_wr[7];
                                    drive_next = 1'b1;
                                    state_next = ST_WR_LOW;
                                end
                                else
                                begin
                                    sda_next   = 1'b1;
                                    drive_next = 1'b0;
                                    state_next = ST_WACK_LOW;
                                end
                            end
                            ST_WACK_LOW:
                            begin
                                scl_next   = 1'b1;
                                state_next = ST_WACK_HIGH;
                            end
                            ST_WACK_HIGH:
                            begin
                                ack_flag_next = ~item.sda_in;
                                scl_next      = 1'b0;
                                sda_next      = 1'b0;
                                drive_next    = 1'b1;
                                state_next    = ST_IDLE;
                                done          = 1'b1;
                            end
                            ST_RD_LOW:
                            begin
                                scl_next   = 1'b1;
                                state_next = ST_RD_HIGH;
                            end
                            ST_RD_HIGH:
                            begin
                                shift_next   = shift_rd;
                                scl_next     = 1'b0;
                                bit_cnt_next = bit_inc;
                                if (bit_inc < BITS_PER_BYTE)
                                begin
                                    state_next = ST_RD_LOW;
                                end
                                else
                                begin
                                    last_read_next = shift_rd;
                                    sda_next       = ack_held_reg;
                                    drive_next     = 1'b1;
                                    state_next     = ST_RACK_LOW;
                                end
                            end
                            ST_RACK_LOW:
                            begin
                                scl_next   = 1'b1;
                                state_next = ST_RACK_HIGH;
                            end
                            ST_RACK_HIGH:
                            begin
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                                drive_next = 1'b1;
                                state_next = ST_IDLE;
                                done       = 1'b1;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ACT_START, ACT_STOP, ACT_WRITE, ACT_READ:
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    delay_next   = 16'd0;
                    bit_cnt_next = 4'd0;
                    unique case (item.action)
                        ACT_START:
                        begin
                            sda_next   = 1'b1;
                            drive_next = 1'b1;
                            scl_next   = 1'b1;
                            state_next = ST_START_A;
                        end
                        ACT_STOP:
                        begin
                            sda_next   = 1'b0;
                            drive_next = 1'b1;
                            state_next = ST_STOP_A;
                        end
                        ACT_WRITE:
                        begin
                            shift_next = item.write_data;
                            scl_next   = 1'b0;
                            sda_next   = item.write_data[7];
                            drive_next = 1'b1;
                            state_next = ST_WR_LOW;
                        end
                        default:
                        begin
                            shift_next    = 8'd0;
                            ack_held_next = item.nack_level;
                            scl_next      = 1'b0;
                            sda_next      = 1'b1;
                            drive_next    = 1'b0;
                            state_next    = ST_RD_LOW;
                        end
                    endcase
                end
            end
            default:
            begin
                // undefined codes leave everything as it is
            end
        endcase
    end

    // Result as seen after this item
    always_comb
    begin
        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.sda_drive = drive_next;
        res_next.busy_res  = (state_next != ST_IDLE);
        res_next.done_res  = done;
        res_next.ack_ok    = ack_flag_next;
        res_next.read_byte = last_read_next;
        res_next.rejected  = rejected;
    end

    // State registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= 4'd0;
            shift_reg     <= 8'd0;
            delay_reg     <= 16'd0;
            ack_flag_reg  <= 1'b0;
            ack_held_reg  <= 1'b0;
            last_read_reg <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            ack_flag_reg  <= ack_flag_next;
            ack_held_reg  <= ack_held_next;
            last_read_reg <= last_read_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drive_reg     <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_engine.sv =====
// I2C master bit engine top level: input register, sequencer, result register.
//
// Takes one command or tick item per clock cycle while the input side does not stall
// and returns exactly one result item for each, through the input register and the
// result register. An item is first captured in an input register; the sequencer then
// applies it to its state and the levels and status go to the result register, so one
// more item can be taken while a result waits; with both registers full the input side
// stalls until the result is taken. Bus timing counts tick items only: every SCL phase
// lasts half_period ticks (zero counts as one). Commands given while a command runs are
// dropped and flagged as rejected. The half period register should be written only
// while no item is in flight; it takes effect at once, also in the middle of a command.
`default_nettype none

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_data,
    i2cm_cmd_if.sink         cmd,
    i2cm_res_if.source       res
);

    logic [15:0] half_period_reg;
    logic        in_valid_reg;
    cmd_t        in_item_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    res_t        res_next;
    logic        advance;
    logic        cmd_xfer;

    // Item moves from input register to result register when the result slot is free or its result is being taken
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_xfer = cmd.valid && cmd.ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_write_en)
        begin
            half_period_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            in_item_reg.action     <= cmd.action;
            in_item_reg.write_data <= cmd.write_data;
            in_item_reg.nack_level <= cmd.nack_level;
            in_item_reg.sda_in     <= cmd.sda_in;
        end
    end

    // Sequencer
    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (in_item_reg),
        .half_period (half_period_reg),
        .res_next    (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_level = out_res_reg.scl_level;
    assign res.sda_level = out_res_reg.sda_level;
    assign res.sda_drive = out_res_reg.sda_drive;
    assign res.busy_res  = out_res_reg.busy_res;
    assign res.done_res  = out_res_reg.done_res;
    assign res.ack_ok    = out_res_reg.ack_ok;
    assign res.read_byte = out_res_reg.read_byte;
    assign res.rejected  = out_res_reg.rejected;

endmodule

`default_nettype wire
